>>> design/pcf_pkg.sv
// ---------------------------------------------------------------------------
// pcf_pkg
// Shared types, constants and CRC-32 helpers for the PNG chunk framer.
// ---------------------------------------------------------------------------
package pcf_pkg;

  localparam int LENGTH_BITS = 24;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
  // crc of the empty IEND chunk, already inverted
  localparam logic [31:0] IEND_CRC = 32'hAE42_6082;
  localparam logic [31:0] ZLIB_HDR_LEN = 32'd6;

  // byte positions inside a begin run
  localparam logic [5:0] B_LEN      = 6'd8;
  localparam logic [5:0] B_TAG      = 6'd12;
  localparam logic [5:0] B_WIDTH    = 6'd16;
  localparam logic [5:0] B_HEIGHT   = 6'd20;
  localparam logic [5:0] B_DEPTH    = 6'd24;
  localparam logic [5:0] B_COLOR    = 6'd25;
  localparam logic [5:0] B_HCRC     = 6'd29;
  localparam logic [5:0] B_IDAT_LEN = 6'd33;
  localparam logic [5:0] B_IDAT_TAG = 6'd37;
  localparam logic [5:0] B_CMF      = 6'd41;
  localparam logic [5:0] B_LAST     = 6'd42;

  // byte positions inside an end run
  localparam logic [5:0] E_DCRC     = 6'd4;
  localparam logic [5:0] E_IEND_LEN = 6'd8;
  localparam logic [5:0] E_TAG      = 6'd12;
  localparam logic [5:0] E_CRC      = 6'd16;
  localparam logic [5:0] E_LAST     = 6'd19;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_DATA   = 2'd1,
    OP_END    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_DEPTH  = 3'd2,
    REG_COLOR  = 3'd3,
    REG_CMF    = 3'd4,
    REG_FLG    = 3'd5,
    REG_LENGTH = 3'd6,
    REG_ADLER  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]            image_width;
    logic [30:0]            image_height;
    logic [4:0]             sample_depth;
    logic [2:0]             color_mode;
    logic [7:0]             zlib_cmf;
    logic [7:0]             zlib_flg;
    logic [LENGTH_BITS-1:0] data_length;
    logic [31:0]            adler_value;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       length_error;
  } out_req_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0: b = 8'd137;
      3'd1: b = 8'd80;
      3'd2: b = 8'd78;
      3'd3: b = 8'd71;
      3'd4: b = 8'd13;
      3'd5: b = 8'd10;
      3'd6: b = 8'd26;
      3'd7: b = 8'd10;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // big endian byte select, sel 0 is the top byte
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      2'd3: b = w[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> design/pcf_cfg_regs.sv
// ---------------------------------------------------------------------------
// pcf_cfg_regs
// Configuration register file: image header fields, zlib header, expected
// data length and Adler-32 value.
// ---------------------------------------------------------------------------
module pcf_cfg_regs
  import pcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  localparam logic [LENGTH_BITS-1:0] LEN_WR_MASK = LENGTH_BITS'(32'h00FF_FFFF);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= 31'd1;
      cfg.image_height <= 31'd1;
      cfg.sample_depth <= 5'd8;
      cfg.color_mode   <= 3'd6;
      cfg.zlib_cmf     <= 8'd120;
      cfg.zlib_flg     <= 8'd1;
      cfg.data_length  <= '0;
      cfg.adler_value  <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  cfg.image_width  <= cfg_data[30:0];
        REG_HEIGHT: cfg.image_height <= cfg_data[30:0];
        REG_DEPTH:  cfg.sample_depth <= cfg_data[4:0];
        REG_COLOR:  cfg.color_mode   <= cfg_data[2:0];
        REG_CMF:    cfg.zlib_cmf     <= cfg_data[7:0];
        REG_FLG:    cfg.zlib_flg     <= cfg_data[7:0];
        REG_LENGTH: cfg.data_length  <= cfg_data[LENGTH_BITS-1:0] & LEN_WR_MASK;
        REG_ADLER:  cfg.adler_value  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/pcf_byte_seq.sv
// ---------------------------------------------------------------------------
// pcf_byte_seq
// Byte sequencer: takes one request, produces the bytes of its run one per
// load slot, folds chunk bytes into the header and data CRCs and counts data.
// ---------------------------------------------------------------------------
module pcf_byte_seq
  import pcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] data_byte,
  input  logic [1:0] op,
  input  logic       load_en,
  output logic       emit,
  output out_req_t   req
);

  logic                   busy;
  logic [5:0]             idx;
  op_t                    op_reg;
  logic                   err_reg;
  logic                   phase;
  logic [31:0]            hcrc;
  logic [31:0]            running_crc;
  logic [LENGTH_BITS-1:0] data_count;
  logic                   count_over;

  op_t        cur_op;
  logic [5:0] cur_idx;
  logic [1:0] off1;
  logic       accept;
  logic       op_ok;
  logic       err_now;
  logic       cur_last;
  logic [7:0] cur_byte;
  logic       fold_h;
  logic       fold_r;

  assign s_tready = load_en && !busy;
  assign accept   = s_tvalid && s_tready;

  assign cur_op  = busy ? op_reg : op_t'(op);
  assign cur_idx = busy ? idx : '0;
  assign off1    = cur_idx[1:0] - 2'd1;

  assign op_ok   = (cur_op == OP_BEGIN) ||
                   (phase && ((cur_op == OP_DATA) || (cur_op == OP_END)));
  assign emit    = load_en && (busy || (s_tvalid && op_ok));
  assign err_now = count_over || (data_count != cfg.data_length);

  always_comb begin
    cur_byte = 8'd0;
    cur_last = 1'b0;
    fold_h   = 1'b0;
    fold_r   = 1'b0;
    unique case (cur_op)
      OP_BEGIN: begin
        cur_last = (cur_idx == B_LAST);
        fold_h   = (cur_idx >= B_TAG) && (cur_idx < B_HCRC);
        fold_r   = (cur_idx >= B_IDAT_TAG);
        priority if (cur_idx < B_LEN)        cur_byte = sig_byte(cur_idx[2:0]);
        else if (cur_idx < B_TAG)            cur_byte = be_byte(IHDR_LEN, cur_idx[1:0]);
        else if (cur_idx < B_WIDTH)          cur_byte = be_byte(TAG_IHDR, cur_idx[1:0]);
        else if (cur_idx < B_HEIGHT)
          cur_byte = be_byte({1'b0, cfg.image_width}, cur_idx[1:0]);
        else if (cur_idx < B_DEPTH)
          cur_byte = be_byte({1'b0, cfg.image_height}, cur_idx[1:0]);
        else if (cur_idx == B_DEPTH)         cur_byte = {3'd0, cfg.sample_depth};
        else if (cur_idx == B_COLOR)         cur_byte = {5'd0, cfg.color_mode};
        else if (cur_idx < B_HCRC)           cur_byte = 8'd0;
        else if (cur_idx < B_IDAT_LEN)       cur_byte = be_byte(~hcrc, off1);
        else if (cur_idx < B_IDAT_TAG)
          cur_byte = be_byte(32'(cfg.data_length) + ZLIB_HDR_LEN, off1);
        else if (cur_idx < B_CMF)            cur_byte = be_byte(TAG_IDAT, off1);
        else if (cur_idx == B_CMF)           cur_byte = cfg.zlib_cmf;
        else                                 cur_byte = cfg.zlib_flg;
      end
      OP_DATA: begin
        cur_last = 1'b1;
        fold_r   = 1'b1;
        cur_byte = data_byte;
      end
      OP_END: begin
        cur_last = (cur_idx == E_LAST);
        fold_r   = (cur_idx < E_DCRC);
        priority if (cur_idx < E_DCRC)       cur_byte = be_byte(cfg.adler_value, cur_idx[1:0]);
        else if (cur_idx < E_IEND_LEN)       cur_byte = be_byte(~running_crc, cur_idx[1:0]);
        else if (cur_idx < E_TAG)            cur_byte = 8'd0;
        else if (cur_idx < E_CRC)            cur_byte = be_byte(TAG_IEND, cur_idx[1:0]);
        else                                 cur_byte = be_byte(IEND_CRC, cur_idx[1:0]);
      end
      default: ;
    endcase
  end

  assign req.out_byte     = cur_byte;
  assign req.last_of_run  = cur_last;
  assign req.length_error = (cur_op == OP_END) && (busy ? err_reg : err_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      idx         <= '0;
      op_reg      <= OP_BEGIN;
      err_reg     <= 1'b0;
      phase       <= 1'b0;
      hcrc        <= CRC_INIT;
      running_crc <= CRC_INIT;
      data_count  <= '0;
      count_over  <= 1'b0;
    end else begin
      if (accept) begin
        op_reg <= cur_op;
      end
      if (emit) begin
        busy <= !cur_last;
        idx  <= cur_idx + 6'd1;
        unique case (cur_op)
          OP_BEGIN: begin
            if (!busy) begin
              hcrc        <= CRC_INIT;
              running_crc <= CRC_INIT;
              data_count  <= '0;
              count_over  <= 1'b0;
              phase       <= 1'b1;
            end
          end
          OP_DATA: begin
            // count saturates and leaves a sticky overflow mark
            if (&data_count) count_over <= 1'b1;
            else             data_count <= data_count + 1'b1;
          end
          OP_END: begin
            if (!busy) begin
              err_reg    <= err_now;
              data_count <= '0;
              count_over <= 1'b0;
              phase      <= 1'b0;
            end
          end
          default: ;
        endcase
        if (fold_h) hcrc <= crc_fold(hcrc, cur_byte);
        if (fold_r) running_crc <= crc_fold(running_crc, cur_byte);
        if ((cur_op == OP_END) && cur_last) running_crc <= CRC_INIT;
      end
    end
  end

endmodule

>>> design/png_chunk_framer_crc32.sv
// ---------------------------------------------------------------------------
// png_chunk_framer_crc32
// The first byte of a request shows on m_tdata in the cycle after it is taken.
// A begin run is 43 bytes, an end run 20 and a data run one; the input is held until a run
// ends, so data bytes stream one per cycle, one per byte sequencer load slot, while m_tready holds no stall.
// Reset: synchronous rst restores register defaults, empties the output stage,
// clears the count and both CRCs and leaves no frame open.
// ---------------------------------------------------------------------------
module png_chunk_framer_crc32
  import pcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser,   // [0] length_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t     cfg;
  out_req_t req;
  out_req_t out_reg;
  logic     emit;
  logic     load_en;

  pcf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcf_byte_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .data_byte (s_tdata),
    .op        (s_tuser),
    .load_en   (load_en),
    .emit      (emit),
    .req       (req)
  );

  // output stage reloads whenever it is empty or being drained
  assign load_en = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_en) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && emit) begin
      out_reg <= req;
    end
  end

  assign m_tdata = out_reg.out_byte;
  assign m_tlast = out_reg.last_of_run;
  assign m_tuser = out_reg.length_error;

endmodule
